[design/pcsp_pkg.sv]
package pcsp_pkg;

  localparam int unsigned ADDR_W     = 48;
  localparam int unsigned STRIDE_W   = 49;
  localparam int unsigned TARGET_W   = 50;
  localparam int unsigned CAND_W     = 64;
  localparam int unsigned CONF_W     = 2;
  localparam int unsigned SHIFT_W    = 4;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam logic [CONF_W-1:0]  CONF_MAX       = 2'd3;
  localparam logic [SHIFT_W-1:0] LINE_SHIFT_RST = 4'd6;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_EMIT
  } pcsp_state_e;

  typedef struct packed {
    logic [ADDR_W-1:0]   tag_pc;
    logic [ADDR_W-1:0]   prev_line;
    logic [STRIDE_W-1:0] stride_lines;
    logic [CONF_W-1:0]   confidence;
  } pcsp_entry_t;

endpackage

[design/pc_stride_prefetcher.sv]
// PC-indexed stride prefetcher.
// Input channel (in_valid_i/in_ready_o) carries one demand access per
// transaction: pc_i, addr_i and is_prefetch_i. Output channel
// (out_valid_o/out_ready_i) carries zero or one
// prefetch_addr_o per demand access, in order.
// cfg_we_i/cfg_wdata_i write line_shift (log2 of line size), reset value 6;
// write it only while the block is idle.
// A direct-mapped table of TABLE_ENTRIES entries (a power of two) sits in a
// synchronous RAM with one read and one write port; a demand access passes
// through RAM read, read-modify-write of the entry, page check and output
// load, in that order, and its result shows on the output once the emit
// step has loaded the output register. A new access is taken only after the
// last one leaves the emit step: read, update and emit around the one
// table RAM run in series. Prefetch-flagged accesses touch no table entry.
// The output register decouples the sides: a new access is taken while a
// result waits; the block stalls in the emit step only if it has a new
// result and the previous one has not been taken.
// Reset clears the per-entry valid flops at once; no clearing pass is needed.
module pc_stride_prefetcher #(
  parameter int unsigned TABLE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [pcsp_pkg::ADDR_W-1:0]         pc_i,
  input  logic [pcsp_pkg::ADDR_W-1:0]         addr_i,
  input  logic                                is_prefetch_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [pcsp_pkg::ADDR_W-1:0]         prefetch_addr_o,
  input  logic                                cfg_we_i,
  input  logic [pcsp_pkg::SHIFT_W-1:0]        cfg_wdata_i
);
  import pcsp_pkg::*;

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  pcsp_state_e          state_q, state_d;
  logic [SHIFT_W-1:0]   line_shift_q;
  logic [ADDR_W-1:0]    pc_q, addr_q, line_q;
  logic [STRIDE_W-1:0]  target_q;
  logic                 emit_pend_q, emit_pend_d;
  logic                 out_valid_q, out_valid_d;
  logic [ADDR_W-1:0]    prefetch_addr_q, prefetch_addr_d;

  logic                 in_accept;
  logic                 rd_en;
  logic                 tbl_we;
  logic                 out_free;
  logic                 out_load;
  logic                 emit_stall;

  pcsp_entry_t          rd_entry;
  logic                 rd_valid;
  pcsp_entry_t          wr_entry;

  logic                 hit;
  logic [STRIDE_W-1:0]  stride_obs;
  logic                 stride_same;
  logic [STRIDE_W-1:0]  stride_new;
  logic [CONF_W-1:0]    conf_new;
  logic [TARGET_W-1:0]  target_w;
  logic [CAND_W-1:0]    cand_w;
  logic                 page_ok;
  logic                 emit;

  pcsp_table #(
    .ENTRIES (TABLE_ENTRIES),
    .IDX_W   (IDX_W)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (rd_en),
    .rd_idx_i   (pc_i[IDX_W-1:0]),
    .rd_entry_o (rd_entry),
    .rd_valid_o (rd_valid),
    .wr_en_i    (tbl_we),
    .wr_idx_i   (pc_q[IDX_W-1:0]),
    .wr_entry_i (wr_entry)
  );

  // entry update
  always_comb begin
    hit         = rd_valid && (rd_entry.tag_pc == pc_q);
    stride_obs  = {1'b0, line_q} - {1'b0, rd_entry.prev_line};
    stride_same = (stride_obs == rd_entry.stride_lines) && (stride_obs != '0);
    if (stride_same) begin
      stride_new = rd_entry.stride_lines;
      conf_new   = (rd_entry.confidence == CONF_MAX) ? CONF_MAX
                                                     : rd_entry.confidence + 1'b1;
    end else begin
      stride_new = stride_obs;
      conf_new   = '0;
    end
    target_w = {2'b00, line_q} + {stride_new[STRIDE_W-1], stride_new};

    if (hit) begin
      wr_entry.tag_pc       = rd_entry.tag_pc;
      wr_entry.prev_line    = line_q;
      wr_entry.stride_lines = stride_new;
      wr_entry.confidence   = conf_new;
    end else begin
      wr_entry.tag_pc       = pc_q;
      wr_entry.prev_line    = line_q;
      wr_entry.stride_lines = '0;
      wr_entry.confidence   = '0;
    end

    if (state_q == S_LOOK) begin
      emit_pend_d = hit && (conf_new != '0) && !target_w[TARGET_W-1];
    end else begin
      emit_pend_d = emit_pend_q;
    end
  end

  // page check
  always_comb begin
    cand_w  = {{(CAND_W-STRIDE_W){1'b0}}, target_q} << line_shift_q;
    page_ok = cand_w[CAND_W-1:PAGE_SHIFT]
              == {{(CAND_W-ADDR_W){1'b0}}, addr_q[ADDR_W-1:PAGE_SHIFT]};
    emit    = emit_pend_q && page_ok;
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept && !is_prefetch_i) begin
          state_d = S_LOOK;
        end
      end
      S_LOOK: begin
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (!emit_stall) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    tbl_we     = 1'b0;
    emit_stall = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        rd_en      = in_valid_i && !is_prefetch_i;
      end
      S_LOOK: begin
        tbl_we = 1'b1;
      end
      S_EMIT: begin
        emit_stall = emit && !out_free;
        out_load   = emit && out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d     = out_valid_q;
    prefetch_addr_d = prefetch_addr_q;
    if (out_load) begin
      out_valid_d     = 1'b1;
      prefetch_addr_d = cand_w[ADDR_W-1:0];
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      line_shift_q <= LINE_SHIFT_RST;
      emit_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      emit_pend_q <= emit_pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        line_shift_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pc_q   <= pc_i;
      addr_q <= addr_i;
      line_q <= addr_i >> line_shift_q;
    end
    if (state_q == S_LOOK) begin
      target_q <= target_w[STRIDE_W-1:0];
    end
    prefetch_addr_q <= prefetch_addr_d;
  end

  assign out_valid_o     = out_valid_q;
  assign prefetch_addr_o = prefetch_addr_q;

  a_wb_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !is_prefetch_i) |=> tbl_we)
    else $error("table write did not follow a lookup");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_same_page: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> (prefetch_addr_d[ADDR_W-1:PAGE_SHIFT] == addr_q[ADDR_W-1:PAGE_SHIFT]))
    else $error("prefetch leaves the demand page");

  a_miss_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK && !hit) |=> !emit_pend_q)
    else $error("tag miss produced a prefetch");

endmodule

[design/pcsp_table.sv]
module pcsp_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned IDX_W   = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output pcsp_pkg::pcsp_entry_t rd_entry_o,
  output logic                 rd_valid_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  pcsp_pkg::pcsp_entry_t wr_entry_i
);
  import pcsp_pkg::*;

  pcsp_entry_t        mem [ENTRIES];
  pcsp_entry_t        rd_entry_q;
  logic [ENTRIES-1:0] valid_q;
  logic               rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_idx_i] <= wr_entry_i;
    end
    if (rd_en_i) begin
      rd_entry_q <= mem[rd_idx_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        valid_q[wr_idx_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_valid_q <= valid_q[rd_idx_i];
      end
    end
  end

  assign rd_entry_o = rd_entry_q;
  assign rd_valid_o = rd_valid_q;

endmodule

[verif/pc_stride_prefetcher_test.sv]
`timescale 1ns / 100ps

module pc_stride_prefetcher_test;
  import pcsp_pkg::*;

  localparam int unsigned TBL_ENTRIES = 256;
  localparam int unsigned HOLD_CYCLES = 300;

  class stride_scoreboard;
    logic [ADDR_W-1:0]          tag_q[TBL_ENTRIES];
    logic [ADDR_W-1:0]          last_q[TBL_ENTRIES];
    logic signed [STRIDE_W-1:0] stride_q[TBL_ENTRIES];
    logic [CONF_W-1:0]          conf_q[TBL_ENTRIES];
    bit                         valid_q[TBL_ENTRIES];
    logic [SHIFT_W-1:0]         line_shift;
    logic [ADDR_W-1:0]          pending_addrs[$];
    int unsigned                mismatches;

    function new();
      foreach (valid_q[i]) begin
        tag_q[i]    = '0;
        last_q[i]   = '0;
        stride_q[i] = '0;
        conf_q[i]   = '0;
        valid_q[i]  = 1'b0;
      end
      line_shift  = LINE_SHIFT_RST;
      mismatches  = 0;
    endfunction

    function void note_access(logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] addr, bit pf);
      logic [ADDR_W-1:0]          line;
      int unsigned                idx;
      logic signed [STRIDE_W-1:0] diff;
      logic signed [TARGET_W-1:0] target;
      logic [CAND_W-1:0]          cand;
      logic [CAND_W-1:0]          addr_w;
      if (pf) return;
      line = addr >> line_shift;
      idx = 32'(pc % TBL_ENTRIES);
      if (valid_q[idx] && tag_q[idx] == pc) begin
        diff = $signed({1'b0, line}) - $signed({1'b0, last_q[idx]});
        if (diff == stride_q[idx] && diff != 0) begin
          if (conf_q[idx] != CONF_MAX) conf_q[idx] = conf_q[idx] + 1'b1;
        end else begin
          stride_q[idx] = diff;
          conf_q[idx] = '0;
        end
        if (conf_q[idx] != '0) begin
          target = $signed({2'b00, line}) + stride_q[idx];
          if (!target[TARGET_W-1]) begin
            cand = {{(CAND_W-TARGET_W){1'b0}}, target} << line_shift;
            addr_w = {{(CAND_W-ADDR_W){1'b0}}, addr};
            if ((cand >> PAGE_SHIFT) == (addr_w >> PAGE_SHIFT))
              pending_addrs.push_back(cand[ADDR_W-1:0]);
          end
        end
      end else begin
        tag_q[idx]    = pc;
        stride_q[idx] = '0;
        conf_q[idx]   = '0;
        valid_q[idx]  = 1'b1;
      end
      last_q[idx] = line;
    endfunction

    function void check_prefetch(logic [ADDR_W-1:0] actual);
      logic [ADDR_W-1:0] want;
      if (pending_addrs.size() == 0) begin
        $error("prefetch_addr: expected none, actual %h", actual);
        mismatches++;
      end else begin
        want = pending_addrs.pop_front();
        if (want !== actual) begin
          $error("prefetch_addr: expected %h, actual %h", want, actual);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return pending_addrs.size();
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [ADDR_W-1:0]   pc_i;
  logic [ADDR_W-1:0]   addr_i;
  logic                is_prefetch_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [ADDR_W-1:0]   prefetch_addr_o;
  logic                cfg_we_i;
  logic [SHIFT_W-1:0]  cfg_wdata_i;

  stride_scoreboard    sb;
  bit                  quiet;
  bit                  hold_req;
  logic [SHIFT_W-1:0]  cur_shift;
  logic [ADDR_W-1:0]   st_pc[4];
  logic [ADDR_W-1:0]   st_line[4];
  longint              st_stride[4];

  pc_stride_prefetcher #(
    .TABLE_ENTRIES(TBL_ENTRIES)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .pc_i           (pc_i),
    .addr_i         (addr_i),
    .is_prefetch_i  (is_prefetch_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .prefetch_addr_o(prefetch_addr_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_prefetch(prefetch_addr_o);
  end

  // receiver: random back-pressure plus one long hold on request
  initial begin
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 10)) @(negedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin
    #1_000_000;
    $display("pc_stride_prefetcher_test: FAIL");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[ADDR_W-1:0];
  endfunction

  function automatic void reseed(int unsigned k);
    int unsigned r;
    st_pc[k] = rand48();
    if ($urandom_range(0, 3) == 0) st_pc[k][7:0] = st_pc[(k + 1) % 4][7:0];
    st_line[k] = rand48() >> cur_shift;
    r = $urandom_range(0, 15);
    if (r == 0) begin
      st_stride[k] = 0;
    end else if (r == 1) begin
      st_stride[k] = longint'($urandom_range(0, 1 << 20)) - (1 << 19);
    end else begin
      st_stride[k] = $urandom_range(1, 4);
      if ($urandom_range(0, 1) == 1) st_stride[k] = -st_stride[k];
    end
  endfunction

  task automatic send_access(logic [ADDR_W-1:0] pc, logic [ADDR_W-1:0] addr, bit pf);
    if (!quiet && $urandom_range(0, 9) == 0) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      repeat ($urandom_range(0, 9)) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid_i    <= 1'b1;
    pc_i          <= pc;
    addr_i        <= addr;
    is_prefetch_i <= pf;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_access(pc, addr, pf);
  endtask

  task automatic settle();
    int unsigned n;
    n = 0;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0 && n < 4000) begin
      @(posedge clk_i);
      n++;
    end
    if (sb.pending() != 0) begin
      $error("prefetch_addr: %0d expected transactions never arrived", sb.pending());
      sb.mismatches += sb.pending();
      sb.pending_addrs.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  task automatic set_line_shift(logic [SHIFT_W-1:0] v);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    sb.line_shift = v;
    cur_shift = v;
  endtask

  task automatic run_phase(int unsigned n_items, bit press);
    int unsigned       done;
    int unsigned       k;
    logic [ADDR_W-1:0] a;
    logic [ADDR_W-1:0] p;
    bit                pf;
    bit                pressed;
    done = 0;
    pressed = 1'b0;
    for (k = 0; k < 4; k++) reseed(k);
    while (done < n_items) begin
      if (press && !pressed && done >= n_items / 4) begin
        hold_req = 1'b1;
        pressed = 1'b1;
      end
      if ($urandom_range(0, 99) < 75) begin
        k = $urandom_range(0, 3);
        if ($urandom_range(0, 19) == 0) reseed(k);
        p = st_pc[k];
        a = (st_line[k] << cur_shift) | (rand48() & ((48'd1 << cur_shift) - 48'd1));
        pf = ($urandom_range(0, 19) == 0);
        if (!pf) st_line[k] = st_line[k] + st_stride[k][ADDR_W-1:0];
      end else begin
        p = rand48();
        a = rand48();
        pf = ($urandom_range(0, 3) == 0);
      end
      send_access(p, a, pf);
      if (!pf) done++;
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] pa;
    logic [ADDR_W-1:0] pb;
    logic [ADDR_W-1:0] pmax;
    sb = new();
    quiet = 1'b0;
    hold_req = 1'b0;
    cur_shift = LINE_SHIFT_RST;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    pc_i = '0;
    addr_i = '0;
    is_prefetch_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // steady stride, ignored prefetch mid-stream, saturation, zero stride
    pa = 48'h0000_1234_5610;
    send_access(pa, 48'h1000, 1'b0);
    send_access(pa, 48'h1040, 1'b0);
    send_access(pa, 48'h1080, 1'b0);
    send_access(pa, 48'h5000, 1'b1);
    send_access(pa, 48'h10C4, 1'b0);
    send_access(pa, 48'h1100, 1'b0);
    send_access(pa, 48'h1140, 1'b0);
    send_access(pa, 48'h1140, 1'b0);
    // target crosses into the next page
    send_access(pa, 48'h1F00, 1'b0);
    send_access(pa, 48'h1F40, 1'b0);
    send_access(pa, 48'h1F80, 1'b0);
    send_access(pa, 48'h1FC0, 1'b0);
    // negative target line
    pb = 48'h0000_0000_0020;
    send_access(pb, 48'h0080, 1'b0);
    send_access(pb, 48'h0040, 1'b0);
    send_access(pb, 48'h0000, 1'b0);
    // field extremes, index conflict
    pmax = '1;
    send_access(pmax, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_access(pmax, 48'hFFFF_FFFF_FFBF, 1'b0);
    send_access(pmax, 48'hFFFF_FFFF_FF7F, 1'b0);
    send_access(pmax, 48'h0000_0000_0000, 1'b0);
    send_access(48'h0, 48'h0, 1'b0);
    send_access(48'h100, 48'h0, 1'b0);
    send_access(48'h0, 48'hFFFF_FFFF_FFFF, 1'b0);
    send_access(48'h100, 48'h40, 1'b0);
    settle();

    set_line_shift(4'd2);
    run_phase(140, 1'b1);
    settle();
    set_line_shift(4'd12);
    run_phase(140, 1'b0);
    settle();
    set_line_shift(4'd0);
    run_phase(140, 1'b0);
    settle();
    set_line_shift(4'd15);
    run_phase(140, 1'b0);
    settle();
    set_line_shift(4'd9);
    run_phase(140, 1'b0);
    settle();
    set_line_shift(4'd4);
    run_phase(140, 1'b0);
    settle();
    set_line_shift(LINE_SHIFT_RST);
    quiet = 1'b1;
    run_phase(140, 1'b0);
    settle();

    if (sb.mismatches == 0) begin
      $display("pc_stride_prefetcher_test: PASS");
    end else begin
      $display("pc_stride_prefetcher_test: FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/pcsp_pkg.sv
design/pcsp_table.sv
design/pc_stride_prefetcher.sv
verif/pc_stride_prefetcher_test.sv
